[sv/lsmr_pkg.sv]
// ----------------------------------------------------------------------------
// lsmr_pkg
// Shared types, register codes and sector bounds for the lidar sector
// minimum range unit.
// ----------------------------------------------------------------------------
package lsmr_pkg;

  // Widths fixed by the register map and the result format
  localparam int ANGLE_BITS = 40;
  localparam int START_BITS = 30;
  localparam int STEP_BITS  = 25;
  localparam int OUT_BITS   = 16;
  localparam int CFG_BITS   = 30;
  localparam int NUM_SECTORS = 3;

  typedef logic signed [ANGLE_BITS-1:0] angle_t;

  // Configuration register indexes
  typedef logic [1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_START_ANGLE = 2'd0;
  localparam cfg_idx_t CFG_ANGLE_STEP  = 2'd1;
  localparam cfg_idx_t CFG_MAX_RANGE   = 2'd2;

  // Register reset values
  localparam logic [START_BITS-1:0] START_ANGLE_RST = 30'h35456B00; // -180000000
  localparam logic [STEP_BITS-1:0]  ANGLE_STEP_RST  = 25'd1000000;
  localparam logic [OUT_BITS-1:0]   MAX_RANGE_RST   = 16'hFFFF;

  // Sector order: left, center, right
  typedef logic [1:0] sector_idx_t;
  localparam sector_idx_t SECTOR_LEFT   = 2'd0;
  localparam sector_idx_t SECTOR_CENTER = 2'd1;
  localparam sector_idx_t SECTOR_RIGHT  = 2'd2;

  localparam angle_t FULL_TURN = 40'sd360000000;

  // Bounds in microdegrees, lower inclusive, upper exclusive
  localparam angle_t SECTOR_LO [NUM_SECTORS] = '{
    -40'sd70000000, -40'sd40000000, 40'sd20000000
  };
  localparam angle_t SECTOR_HI [NUM_SECTORS] = '{
    -40'sd20000000, 40'sd40000000, 40'sd70000000
  };

  // Per-sample control flags
  typedef struct packed {
    logic sample_valid;
    logic last_sample;
  } smp_ctl_t;

  // An angle above a half turn is folded down by a full turn. Every bound
  // sits below a half turn, so this equals a hit on the bounds or on the
  // bounds shifted up by a full turn, with no subtract on the angle.
  function automatic logic in_sector(angle_t a, sector_idx_t k);
    logic direct_hit;
    logic folded_hit;
    direct_hit = (a >= SECTOR_LO[k]) && (a < SECTOR_HI[k]);
    folded_hit = (a >= SECTOR_LO[k] + FULL_TURN) && (a < SECTOR_HI[k] + FULL_TURN);
    return direct_hit || folded_hit;
  endfunction

endpackage

[sv/lsmr_sector_track.sv]
// ----------------------------------------------------------------------------
// lsmr_sector_track
// Per-sector running minimum of valid ranges; gives the finished minima of
// a scan in the cycle its last sample is taken.
// ----------------------------------------------------------------------------
module lsmr_sector_track #(
  parameter int RANGE_BITS = 16
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   upd_en,
  input  lsmr_pkg::angle_t                       angle,
  input  logic [RANGE_BITS-1:0]                  range_val,
  input  lsmr_pkg::smp_ctl_t                     ctl,
  input  logic [lsmr_pkg::OUT_BITS-1:0]          max_range,
  output logic [lsmr_pkg::NUM_SECTORS-1:0][lsmr_pkg::OUT_BITS-1:0] res_min
);

  localparam int EXT_BITS = (RANGE_BITS > lsmr_pkg::OUT_BITS) ? RANGE_BITS
                                                               : lsmr_pkg::OUT_BITS;

  logic [RANGE_BITS-1:0]                min_r   [lsmr_pkg::NUM_SECTORS];
  logic [RANGE_BITS-1:0]                min_nxt [lsmr_pkg::NUM_SECTORS];
  logic [lsmr_pkg::NUM_SECTORS-1:0]     hit_r;
  logic [lsmr_pkg::NUM_SECTORS-1:0]     hit_nxt;
  logic [EXT_BITS-1:0]                  min_ext [lsmr_pkg::NUM_SECTORS];

  // Compare the sample against each sector and its running minimum
  always_comb begin
    for (int k = 0; k < lsmr_pkg::NUM_SECTORS; k++) begin
      logic take;
      take = ctl.sample_valid &&
             lsmr_pkg::in_sector(angle, lsmr_pkg::sector_idx_t'(k)) &&
             (!hit_r[k] || (range_val < min_r[k]));
      min_nxt[k] = take ? range_val : min_r[k];
      hit_nxt[k] = hit_r[k] | take;
      min_ext[k] = EXT_BITS'(min_nxt[k]);
      res_min[k] = hit_nxt[k] ? min_ext[k][lsmr_pkg::OUT_BITS-1:0] : max_range;
    end
  end

  // Hit flags: clear at the end of each scan
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r <= '0;
    end else if (upd_en) begin
      hit_r <= ctl.last_sample ? '0 : hit_nxt;
    end
  end

  // Minima: reload all ones at the end of each scan
  always_ff @(posedge clk) begin
    if (upd_en) begin
      for (int k = 0; k < lsmr_pkg::NUM_SECTORS; k++) begin
        min_r[k] <= ctl.last_sample ? {RANGE_BITS{1'b1}} : min_nxt[k];
      end
    end
  end

endmodule

[sv/lidar_sector_min_range_unit.sv]
// ----------------------------------------------------------------------------
// lidar_sector_min_range_unit
// Minimum lidar range in three fixed angular sectors over each scan.
// ----------------------------------------------------------------------------
// Takes one range word per cycle, save in the stall below. Each word is
// registered with its beam angle (start angle on the first word of a scan,
// then stepped by the angle step); sector compares and minimum updates run
// from that register, and a scan's result word is loaded into the output
// register as its last sample leaves. The only stall is a last sample
// sitting in the input register while the previous result word is still
// held unread in the output register; the input then waits until that word
// is taken. Register writes apply to the next scan (start angle) or the
// next step (angle step); write them while the unit is idle.
module lidar_sector_min_range_unit #(
  parameter int RANGE_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // configuration
  input  logic                                 cfg_wr_en,
  input  logic [1:0]                           cfg_index,
  input  logic [lsmr_pkg::CFG_BITS-1:0]        cfg_wdata,
  // sample input
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [RANGE_BITS-1:0]                in_range_sample,
  input  logic                                 in_sample_valid,
  input  logic                                 in_last_sample,
  // result output
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [lsmr_pkg::OUT_BITS-1:0]        out_left_min,
  output logic [lsmr_pkg::OUT_BITS-1:0]        out_center_min,
  output logic [lsmr_pkg::OUT_BITS-1:0]        out_right_min
);

  localparam int AB = lsmr_pkg::ANGLE_BITS;
  localparam int SB = lsmr_pkg::START_BITS;
  localparam int PB = lsmr_pkg::STEP_BITS;

  logic [SB-1:0]                  start_angle_r;
  logic [PB-1:0]                  angle_step_r;
  logic [lsmr_pkg::OUT_BITS-1:0]  max_range_r;

  logic                           in_scan_r;
  lsmr_pkg::angle_t               beam_r;
  lsmr_pkg::angle_t               cur_angle;
  logic                           accept;

  logic                           s1_valid_r;
  lsmr_pkg::angle_t               s1_angle_r;
  logic [RANGE_BITS-1:0]          s1_range_r;
  lsmr_pkg::smp_ctl_t             s1_ctl_r;
  logic                           s1_adv;

  logic [lsmr_pkg::NUM_SECTORS-1:0][lsmr_pkg::OUT_BITS-1:0] res_min;
  logic                           out_valid_r;
  logic [lsmr_pkg::OUT_BITS-1:0]  left_r;
  logic [lsmr_pkg::OUT_BITS-1:0]  center_r;
  logic [lsmr_pkg::OUT_BITS-1:0]  right_r;

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_angle_r <= lsmr_pkg::START_ANGLE_RST;
      angle_step_r  <= lsmr_pkg::ANGLE_STEP_RST;
      max_range_r   <= lsmr_pkg::MAX_RANGE_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        lsmr_pkg::CFG_START_ANGLE: start_angle_r <= cfg_wdata[SB-1:0];
        lsmr_pkg::CFG_ANGLE_STEP:  angle_step_r  <= cfg_wdata[PB-1:0];
        lsmr_pkg::CFG_MAX_RANGE:   max_range_r   <= cfg_wdata[lsmr_pkg::OUT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Handshake: hold a last sample back only while the result is unread
  assign s1_adv   = s1_valid_r && !(s1_ctl_r.last_sample && out_valid_r && !out_ready);
  assign in_ready = !s1_valid_r || s1_adv;
  assign accept   = in_valid && in_ready;

  // Angle of the word being taken
  assign cur_angle = in_scan_r ? beam_r
                               : lsmr_pkg::angle_t'({{(AB-SB){start_angle_r[SB-1]}},
                                                     start_angle_r});

  // Advance the beam angle on every accepted word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_scan_r <= 1'b0;
    end else if (accept) begin
      in_scan_r <= !in_last_sample;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      beam_r <= cur_angle + lsmr_pkg::angle_t'({{(AB-PB){angle_step_r[PB-1]}},
                                                angle_step_r});
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (accept) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_angle_r            <= cur_angle;
      s1_range_r            <= in_range_sample;
      s1_ctl_r.sample_valid <= in_sample_valid;
      s1_ctl_r.last_sample  <= in_last_sample;
    end
  end

  // Sector minima
  lsmr_sector_track #(
    .RANGE_BITS (RANGE_BITS)
  ) u_track (
    .clk       (clk),
    .rst_n     (rst_n),
    .upd_en    (s1_adv),
    .angle     (s1_angle_r),
    .range_val (s1_range_r),
    .ctl       (s1_ctl_r),
    .max_range (max_range_r),
    .res_min   (res_min)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && s1_ctl_r.last_sample) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_ctl_r.last_sample) begin
      left_r   <= res_min[lsmr_pkg::SECTOR_LEFT];
      center_r <= res_min[lsmr_pkg::SECTOR_CENTER];
      right_r  <= res_min[lsmr_pkg::SECTOR_RIGHT];
    end
  end

  assign out_valid      = out_valid_r;
  assign out_left_min   = left_r;
  assign out_center_min = center_r;
  assign out_right_min  = right_r;

endmodule
